[rtl/ice_refractive_index_profile_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the refractive index profile unit
// Shared property wrappers; each expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef ICE_REFRACTIVE_INDEX_PROFILE_UNIT_MACROS_SVH
`define ICE_REFRACTIVE_INDEX_PROFILE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define IRIP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IRIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/irip_pkg.sv]
// ----------------------------------------------------------------------------
// irip_pkg
// Shared widths, constants, coefficient tables and control types of the
// refractive index profile unit.
// ----------------------------------------------------------------------------
`default_nettype none

package irip_pkg;

    // bump table size and derived widths
    localparam int MAX_PERTURB = 8;
    localparam int CNT_W       = $clog2(MAX_PERTURB + 1);
    localparam int IDX_W       = (MAX_PERTURB > 1) ? $clog2(MAX_PERTURB) : 1;

    // field widths
    localparam int DEPTH_W = 24;
    localparam int AMP_W   = 17;
    localparam int WID_W   = 23;
    localparam int INDEX_W = 20;
    localparam int ACC_W   = 24;
    localparam int T_W     = 26;
    localparam int Q30_W   = 31;
    localparam int RQ_W    = 19;

    // fixed-point constants
    localparam logic [Q30_W-1:0]          ONE_Q30    = 31'd1073741824;
    localparam logic [Q30_W-1:0]          E1_Q30     = 31'd395007543;
    localparam logic signed [ACC_W-1:0]   COEF_A     = 24'sd116654;
    localparam logic [INDEX_W-1:0]        INDEX_MAX  = 20'hFFFFF;
    localparam logic [INDEX_W-1:0]        INDEX_ONE  = 20'd65536;
    localparam logic [4:0]                N_LIMIT    = 5'd24;
    localparam logic [4:0]                K_LAST     = 5'd16;
    localparam logic [4:0]                DIV_LAST   = 5'd18;

    typedef enum logic [1:0] {
        ACT_EVAL  = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_ZERO_WIDTH = 2'd2,
        STAT_UNUSED     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_UPDATE,
        OP_BASE_T,
        OP_EXP_SETUP,
        OP_EXP_MUL,
        OP_EXP_DIVQ,
        OP_EXP_DIVC,
        OP_EXP_POW,
        OP_BASE_ACC,
        OP_BUMP_DIFF,
        OP_BUMP_CHK,
        OP_DIV_STEP,
        OP_SQUARE,
        OP_BUMP_ACC,
        OP_RESULT
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_BASE_T,
        S_EXP_SETUP,
        S_EXP_MUL,
        S_EXP_DIVQ,
        S_EXP_DIVC,
        S_EXP_POW,
        S_BASE_ACC,
        S_BUMP_LOOP,
        S_BUMP_CHK,
        S_DIV,
        S_SQUARE,
        S_BUMP_ACC,
        S_RESULT
    } state_t;

    // command from controller to datapath
    typedef struct packed {
        op_t op;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        act_t act;
        logic air;
        logic n_big;
        logic n_zero;
        logic k_last;
        logic div_last;
        logic far;
        logic bump_done;
        logic out_free;
    } stat_t;

    // B in Q0.16; unused select falls back to set 0
    function automatic logic [14:0] coef_b(input logic [2:0] sel);
        logic [14:0] b;
        unique case (sel)
            3'd1:    b = 15'd30409;
            3'd2:    b = 15'd30147;
            3'd3:    b = 15'd30147;
            3'd4:    b = 15'd27722;
            3'd5:    b = 15'd31457;
            3'd6:    b = 15'd28508;
            default: b = 15'd27984;
        endcase
        return b;
    endfunction

    // C in Q0.24
    function automatic logic [18:0] coef_c(input logic [2:0] sel);
        logic [18:0] c;
        unique case (sel)
            3'd1:    c = 19'd409364;
            3'd2:    c = 19'd486539;
            3'd3:    c = 19'd452985;
            3'd4:    c = 19'd452985;
            3'd5:    c = 19'd335544;
            3'd6:    c = 19'd268435;
            default: c = 19'd234881;
        endcase
        return c;
    endfunction

    // ceil(2^32 / k) for the series divisors 1..16
    function automatic logic [32:0] recip(input logic [4:0] k);
        logic [32:0] r;
        unique case (k)
            5'd2:    r = 33'd2147483648;
            5'd3:    r = 33'd1431655766;
            5'd4:    r = 33'd1073741824;
            5'd5:    r = 33'd858993460;
            5'd6:    r = 33'd715827883;
            5'd7:    r = 33'd613566757;
            5'd8:    r = 33'd536870912;
            5'd9:    r = 33'd477218589;
            5'd10:   r = 33'd429496730;
            5'd11:   r = 33'd390451573;
            5'd12:   r = 33'd357913942;
            5'd13:   r = 33'd330382100;
            5'd14:   r = 33'd306783379;
            5'd15:   r = 33'd286331154;
            5'd16:   r = 33'd268435456;
            default: r = 33'd4294967296;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/ice_refractive_index_profile_unit.sv]
// Add, clear, unused action or depth above surface go from the update straight to result.
// Evaluation runs one exponential for the base, then checks each stored bump; a near bump adds
// a 19-step bit-serial division, a square, one exponential and an accumulate.
// Each exponential runs its series terms (multiply, quotient, correction), then n power steps; none when n > 24.
// One item at a time; the next beat is taken the cycle after the result loads.
// Reset clears the bump count, model select and output valid; table is unset.
// ----------------------------------------------------------------------------
// ice_refractive_index_profile_unit
// Refractive index of ice versus depth: exponential firn profile plus a table
// of Gaussian bumps, with add and clear commands and saturated Q4.16 output.
// ----------------------------------------------------------------------------
`default_nettype none

module ice_refractive_index_profile_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [2:0]                          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          action,
    input  wire logic signed [irip_pkg::DEPTH_W-1:0] depth,
    input  wire logic signed [irip_pkg::AMP_W-1:0]   amplitude,
    input  wire logic [irip_pkg::WID_W-1:0]          width,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [irip_pkg::INDEX_W-1:0]             index,
    output logic                                     in_air,
    output logic [1:0]                               status
);
    import irip_pkg::*;

    ctrl_t ctrl;
    stat_t st;

    // register writes always taken
    assign cfg_ready = 1'b1;

    irip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .ctrl     (ctrl)
    );

    irip_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .st           (st),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .in_action    (action),
        .in_depth     (depth),
        .in_amplitude (amplitude),
        .in_width     (width),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_index    (index),
        .out_in_air   (in_air),
        .out_status   (status)
    );

endmodule

`default_nettype wire

[rtl/irip_ctrl.sv]
// ----------------------------------------------------------------------------
// irip_ctrl
// Sequencer of the profile unit: steps the datapath through table updates,
// the base exponential and the walk over the stored bumps.
// ----------------------------------------------------------------------------
`default_nettype none

module irip_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire irip_pkg::stat_t st,
    output irip_pkg::ctrl_t      ctrl
);
    import irip_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;  // 0 base term, 1 bump term

    // state and phase registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_UPDATE;
            S_UPDATE:
                if (st.act == ACT_EVAL && !st.air)
                    state_next = S_BASE_T;
                else
                    state_next = S_RESULT;
            S_BASE_T:
            begin
                phase_next = 1'b0;
                state_next = S_EXP_SETUP;
            end
            S_EXP_SETUP:
                if (st.n_big)
                    state_next = phase_reg ? S_BUMP_ACC : S_BASE_ACC;
                else
                    state_next = S_EXP_MUL;
            S_EXP_MUL:
                state_next = S_EXP_DIVQ;
            S_EXP_DIVQ:
                state_next = S_EXP_DIVC;
            S_EXP_DIVC:
                state_next = st.k_last ? S_EXP_POW : S_EXP_MUL;
            S_EXP_POW:
                if (st.n_zero)
                    state_next = phase_reg ? S_BUMP_ACC : S_BASE_ACC;
            S_BASE_ACC:
                state_next = S_BUMP_LOOP;
            S_BUMP_LOOP:
                state_next = st.bump_done ? S_RESULT : S_BUMP_CHK;
            S_BUMP_CHK:
                state_next = st.far ? S_BUMP_LOOP : S_DIV;
            S_DIV:
                if (st.div_last)
                    state_next = S_SQUARE;
            S_SQUARE:
            begin
                phase_next = 1'b1;
                state_next = S_EXP_SETUP;
            end
            S_BUMP_ACC:
                state_next = S_BUMP_LOOP;
            S_RESULT:
                if (st.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        in_ready = 1'b0;
        ctrl.op  = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    ctrl.op = OP_LOAD;
            end
            S_UPDATE:    ctrl.op = OP_UPDATE;
            S_BASE_T:    ctrl.op = OP_BASE_T;
            S_EXP_SETUP: ctrl.op = OP_EXP_SETUP;
            S_EXP_MUL:   ctrl.op = OP_EXP_MUL;
            S_EXP_DIVQ:  ctrl.op = OP_EXP_DIVQ;
            S_EXP_DIVC:  ctrl.op = OP_EXP_DIVC;
            S_EXP_POW:
                if (!st.n_zero)
                    ctrl.op = OP_EXP_POW;
            S_BASE_ACC:  ctrl.op = OP_BASE_ACC;
            S_BUMP_LOOP:
                if (!st.bump_done)
                    ctrl.op = OP_BUMP_DIFF;
            S_BUMP_CHK:  ctrl.op = OP_BUMP_CHK;
            S_DIV:       ctrl.op = OP_DIV_STEP;
            S_SQUARE:    ctrl.op = OP_SQUARE;
            S_BUMP_ACC:  ctrl.op = OP_BUMP_ACC;
            S_RESULT:
                if (st.out_free)
                    ctrl.op = OP_RESULT;
            default:     ctrl.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/irip_datapath.sv]
// ----------------------------------------------------------------------------
// irip_datapath
// Registers, bump table, exponential series unit, bump divider, accumulator
// and output register of the profile unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ice_refractive_index_profile_unit_macros.svh"

module irip_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire irip_pkg::ctrl_t                     ctrl,
    output irip_pkg::stat_t                          st,
    input  wire logic                                cfg_we,
    input  wire logic [2:0]                          cfg_data,
    input  wire logic [1:0]                          in_action,
    input  wire logic signed [irip_pkg::DEPTH_W-1:0] in_depth,
    input  wire logic signed [irip_pkg::AMP_W-1:0]   in_amplitude,
    input  wire logic [irip_pkg::WID_W-1:0]          in_width,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [irip_pkg::INDEX_W-1:0]             out_index,
    output logic                                     out_in_air,
    output logic [1:0]                               out_status
);
    import irip_pkg::*;

    // control state
    logic [2:0]              model_reg, model_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;

    // payload state
    act_t                    act_reg, act_next;
    logic signed [DEPTH_W-1:0] z_reg, z_next;
    logic signed [AMP_W-1:0] amp_reg, amp_next;
    logic [WID_W-1:0]        wid_reg, wid_next;
    status_t                 stat_reg, stat_next;
    logic signed [DEPTH_W-1:0] center_reg [MAX_PERTURB];
    logic signed [AMP_W-1:0] bamp_reg [MAX_PERTURB];
    logic [WID_W-1:0]        bwid_reg [MAX_PERTURB];
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [T_W-1:0]          t_reg, t_next;
    logic [4:0]              n_reg, n_next;
    logic [Q30_W-1:0]        f_reg, f_next;
    logic [Q30_W-1:0]        term_reg, term_next;
    logic [Q30_W-1:0]        x_reg, x_next;
    logic [Q30_W-1:0]        q_reg, q_next;
    logic [4:0]              k_reg, k_next;
    logic signed [31:0]      sum_reg, sum_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [24:0]             u_reg, u_next;
    logic [23:0]             rem_reg, rem_next;
    logic [RQ_W-1:0]         dq_reg, dq_next;
    logic [4:0]              dcnt_reg, dcnt_next;
    logic [INDEX_W-1:0]      index_reg, index_next;
    logic                    air_out_reg, air_out_next;
    status_t                 status_reg, status_next;

    // combinational helpers
    logic [IDX_W-1:0]        wr_idx, rd_idx;
    logic                    tab_we;
    logic                    air;
    logic [DEPTH_W-1:0]      mag;
    logic [42:0]             base_prod;
    logic [T_W-17:0]         t_hi;
    logic [61:0]             mul_prod;
    logic [63:0]             div_prod;
    logic [35:0]             qk;
    logic [Q30_W-1:0]        term_new;
    logic [Q30_W-1:0]        r_clamp;
    logic [61:0]             pow_prod;
    logic [45:0]             b_prod;
    logic signed [DEPTH_W:0] diff;
    logic [24:0]             u_abs;
    logic [25:0]             w8;
    logic [24:0]             sh;
    logic                    ge;
    logic [37:0]             sq_prod;
    logic [AMP_W-1:0]        amp_abs;
    logic [47:0]             c_prod;
    logic [INDEX_W-1:0]      sat_idx;

    assign wr_idx = count_reg[IDX_W-1:0];
    assign rd_idx = i_reg[IDX_W-1:0];
    assign air    = (z_reg > 0);
    assign t_hi   = t_reg[T_W-1:16];

    // arithmetic shared across steps
    always_comb
    begin
        mag       = DEPTH_W'(-z_reg);
        base_prod = 43'(coef_c(model_reg)) * 43'(mag);
        mul_prod  = 62'(term_reg) * 62'(f_reg);
        div_prod  = 64'(x_reg) * 64'(recip(k_reg));
        qk        = 36'(q_reg) * 36'(k_reg);
        term_new  = (qk > 36'(x_reg)) ? (q_reg - 31'd1) : q_reg;
        r_clamp   = (sum_reg < 0) ? '0 : sum_reg[Q30_W-1:0];
        pow_prod  = 62'(r_clamp) * 62'(E1_Q30);
        b_prod    = 46'(coef_b(model_reg)) * 46'(r_clamp);
        diff      = (DEPTH_W+1)'(z_reg) - (DEPTH_W+1)'(center_reg[rd_idx]);
        u_abs     = (diff < 0) ? 25'(-diff) : 25'(diff);
        w8        = {bwid_reg[rd_idx], 3'b000};
        sh        = {rem_reg, dq_reg[RQ_W-1]};
        ge        = (sh >= 25'(bwid_reg[rd_idx]));
        sq_prod   = 38'(dq_reg) * 38'(dq_reg);
        amp_abs   = (bamp_reg[rd_idx] < 0) ? AMP_W'(-bamp_reg[rd_idx])
                                           : AMP_W'(bamp_reg[rd_idx]);
        c_prod    = 48'(amp_abs) * 48'(r_clamp);
        if (acc_reg < 0)
            sat_idx = '0;
        else if (acc_reg > $signed(ACC_W'(INDEX_MAX)))
            sat_idx = INDEX_MAX;
        else
            sat_idx = acc_reg[INDEX_W-1:0];
    end

    // next values per command
    always_comb
    begin
        model_next     = cfg_we ? cfg_data : model_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        act_next       = act_reg;
        z_next         = z_reg;
        amp_next       = amp_reg;
        wid_next       = wid_reg;
        stat_next      = stat_reg;
        i_next         = i_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        f_next         = f_reg;
        term_next      = term_reg;
        x_next         = x_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        u_next         = u_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        dcnt_next      = dcnt_reg;
        index_next     = index_reg;
        air_out_next   = air_out_reg;
        status_next    = status_reg;
        tab_we         = 1'b0;
        unique case (ctrl.op)
            OP_LOAD:
            begin
                act_next  = act_t'(in_action);
                z_next    = in_depth;
                amp_next  = in_amplitude;
                wid_next  = in_width;
                stat_next = STAT_OK;
            end
            OP_UPDATE:
                // add checks full before zero width
                if (act_reg == ACT_ADD)
                begin
                    if (count_reg == CNT_W'(MAX_PERTURB))
                        stat_next = STAT_FULL;
                    else if (wid_reg == '0)
                        stat_next = STAT_ZERO_WIDTH;
                    else
                    begin
                        tab_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (act_reg == ACT_CLEAR)
                    count_next = '0;
            OP_BASE_T:
                t_next = base_prod[16 +: T_W];
            OP_EXP_SETUP:
            begin
                n_next    = t_hi[4:0];
                f_next    = {1'b0, t_reg[15:0], 14'b0};
                term_next = ONE_Q30;
                k_next    = 5'd1;
                sum_next  = (t_hi > (T_W-16)'(N_LIMIT)) ? 32'sd0 : 32'(ONE_Q30);
            end
            OP_EXP_MUL:
                x_next = mul_prod[30 +: Q30_W];
            OP_EXP_DIVQ:
                q_next = div_prod[32 +: Q30_W];
            OP_EXP_DIVC:
            begin
                term_next = term_new;
                if (k_reg[0])
                    sum_next = sum_reg - $signed(32'(term_new));
                else
                    sum_next = sum_reg + $signed(32'(term_new));
                k_next = k_reg + 5'd1;
            end
            OP_EXP_POW:
            begin
                sum_next = $signed(32'(pow_prod[30 +: Q30_W]));
                n_next   = n_reg - 5'd1;
            end
            OP_BASE_ACC:
            begin
                acc_next = COEF_A - $signed(ACC_W'(b_prod[45:30]));
                i_next   = '0;
            end
            OP_BUMP_DIFF:
                u_next = u_abs;
            OP_BUMP_CHK:
                if (26'(u_reg) >= w8)
                    i_next = i_reg + 1'b1;
                else
                begin
                    rem_next  = 24'(u_reg[24:3]);
                    dq_next   = {u_reg[2:0], 16'b0};
                    dcnt_next = '0;
                end
            OP_DIV_STEP:
            begin
                rem_next  = ge ? 24'(sh - 25'(bwid_reg[rd_idx])) : sh[23:0];
                dq_next   = {dq_reg[RQ_W-2:0], ge};
                dcnt_next = dcnt_reg + 5'd1;
            end
            OP_SQUARE:
                t_next = T_W'(sq_prod[37:17]);
            OP_BUMP_ACC:
            begin
                if (bamp_reg[rd_idx] < 0)
                    acc_next = acc_reg - $signed(ACC_W'(c_prod[47:30]));
                else
                    acc_next = acc_reg + $signed(ACC_W'(c_prod[47:30]));
                i_next = i_reg + 1'b1;
            end
            OP_RESULT:
            begin
                out_valid_next = 1'b1;
                status_next    = stat_reg;
                if (act_reg == ACT_EVAL)
                begin
                    index_next   = air ? INDEX_ONE : sat_idx;
                    air_out_next = air;
                end
                else
                begin
                    index_next   = '0;
                    air_out_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            model_reg     <= model_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        z_reg       <= z_next;
        amp_reg     <= amp_next;
        wid_reg     <= wid_next;
        stat_reg    <= stat_next;
        i_reg       <= i_next;
        t_reg       <= t_next;
        n_reg       <= n_next;
        f_reg       <= f_next;
        term_reg    <= term_next;
        x_reg       <= x_next;
        q_reg       <= q_next;
        k_reg       <= k_next;
        sum_reg     <= sum_next;
        acc_reg     <= acc_next;
        u_reg       <= u_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        dcnt_reg    <= dcnt_next;
        index_reg   <= index_next;
        air_out_reg <= air_out_next;
        status_reg  <= status_next;
    end

    // bump table write
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            center_reg[wr_idx] <= z_reg;
            bamp_reg[wr_idx]   <= amp_reg;
            bwid_reg[wr_idx]   <= wid_reg;
        end
    end

    // status to controller
    always_comb
    begin
        st.act       = act_reg;
        st.air       = air;
        st.n_big     = (t_hi > (T_W-16)'(N_LIMIT));
        st.n_zero    = (n_reg == '0);
        st.k_last    = (k_reg == K_LAST);
        st.div_last  = (dcnt_reg == DIV_LAST);
        st.far       = (26'(u_reg) >= w8);
        st.bump_done = (i_reg == count_reg);
        st.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = index_reg;
    assign out_in_air = air_out_reg;
    assign out_status = status_reg;

    `IRIP_ASSERT_IMPLY(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_PERTURB),
        "bump count beyond table size")
    `IRIP_ASSERT_IMPLY(a_load_free, ctrl.op == OP_RESULT, !out_valid_reg || out_ready,
        "result loaded over a waiting beat")
    `IRIP_ASSERT_IMPLY(a_div_rem, ctrl.op == OP_DIV_STEP,
        25'(rem_reg) < 25'(bwid_reg[rd_idx]), "divider remainder not below width")
    `IRIP_ASSERT_NEXT(a_add_grows,
        ctrl.op == OP_UPDATE && act_reg == ACT_ADD
            && count_reg != CNT_W'(MAX_PERTURB) && wid_reg != '0,
        count_reg == $past(count_reg) + 1'b1, "accepted add did not grow table")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Refractive index profile unit testbench
// Drives evaluate, add-bump, clear and unused commands under random idling on
// both channels. A bit-exact fixed-point model predicts index, in_air and
// status, and a scoreboard compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

class index_scoreboard;
    int unsigned errors;
    bit [2:0] model_sel;
    logic signed [23:0] ctr [8];
    logic signed [16:0] amp [8];
    logic [22:0] wid [8];
    int unsigned count;
    bit [19:0] exp_index [$];
    bit exp_air [$];
    bit [1:0] exp_status [$];

    function new();
        errors = 0;
        model_sel = 0;
        count = 0;
    endfunction

    // exp(-f), f in Q0.30 up to 1.0, by a truncated series; result in Q0.30
    function longint unsigned series(longint unsigned f);
        longint unsigned term;
        longint acc;
        term = 64'd1 << 30;
        acc = 64'sd1 << 30;
        for (int k = 1; k <= 16; k++)
        begin
            term = ((term * f) >> 30) / k;
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        return (acc < 0) ? 0 : longint'(acc);
    endfunction

    // exp(-t), t in Q16: fractional series, then one multiply per whole unit
    function longint unsigned exp_neg(longint unsigned t);
        longint unsigned n, r, e1;
        n = t >> 16;
        if (n > 24)
            return 0;
        r = series((t & 64'hFFFF) << 14);
        e1 = series(64'd1 << 30);
        for (longint unsigned i = 0; i < n; i++)
            r = (r * e1) >> 30;
        return r;
    endfunction

    function bit [19:0] profile(longint z);
        longint unsigned bc, cc, t, u, r, c;
        longint acc, d, a;
        case (model_sel)
            3'd1: begin bc = 30409; cc = 409364; end
            3'd2: begin bc = 30147; cc = 486539; end
            3'd3: begin bc = 30147; cc = 452985; end
            3'd4: begin bc = 27722; cc = 452985; end
            3'd5: begin bc = 31457; cc = 335544; end
            3'd6: begin bc = 28508; cc = 268435; end
            default: begin bc = 27984; cc = 234881; end
        endcase
        t = (cc * longint'(-z)) >> 16;
        acc = 116654 - longint'((bc * exp_neg(t)) >> 30);
        // accumulate the stored bumps within eight sigma
        for (int i = 0; i < count; i++)
        begin
            d = z - longint'(ctr[i]);
            u = (d < 0) ? -d : d;
            r = (u << 16) / wid[i];
            if (r < (64'd8 << 16))
            begin
                a = longint'(amp[i]);
                c = (longint'(a < 0 ? -a : a) * exp_neg((r * r) >> 17)) >> 30;
                acc = (a < 0) ? acc - longint'(c) : acc + longint'(c);
            end
        end
        if (acc < 0)
            return 0;
        if (acc > 1048575)
            return 20'hFFFFF;
        return acc[19:0];
    endfunction

    function void note_command(irip_pkg::act_t act, logic signed [23:0] z,
                               logic signed [16:0] a, logic [22:0] w);
        bit [19:0] ix;
        bit air;
        irip_pkg::status_t st;
        ix = 0;
        air = 0;
        st = irip_pkg::STAT_OK;
        case (act)
            irip_pkg::ACT_EVAL:
                if (z > 0)
                begin
                    ix = 65536;
                    air = 1;
                end
                else
                    ix = profile(longint'(z));
            irip_pkg::ACT_ADD:
                if (count >= 8)
                    st = irip_pkg::STAT_FULL;
                else if (w == 0)
                    st = irip_pkg::STAT_ZERO_WIDTH;
                else
                begin
                    ctr[count] = z;
                    amp[count] = a;
                    wid[count] = w;
                    count++;
                end
            irip_pkg::ACT_CLEAR:
                count = 0;
            default: ;
        endcase
        exp_index = {exp_index, ix};
        exp_air = {exp_air, air};
        exp_status = {exp_status, st};
    endfunction

    function void check_result(bit [19:0] ix, bit air, bit [1:0] st);
        bit [19:0] e_ix;
        bit e_air;
        bit [1:0] e_st;
        if (exp_index.size() == 0)
        begin
            $error("unexpected result beat: index %0d", ix);
            errors++;
            return;
        end
        e_ix = exp_index.pop_front();
        e_air = exp_air.pop_front();
        e_st = exp_status.pop_front();
        if (ix !== e_ix)
        begin
            $error("index: expected %0d actual %0d", e_ix, ix);
            errors++;
        end
        if (air !== e_air)
        begin
            $error("in_air: expected %0d actual %0d", e_air, air);
            errors++;
        end
        if (st !== e_st)
        begin
            $error("status: expected %0d actual %0d", e_st, st);
            errors++;
        end
    endfunction

    function int pending();
        return exp_index.size();
    endfunction
endclass

module testbench;
    import irip_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [1:0] action = 0;
    logic signed [DEPTH_W-1:0] depth = 0;
    logic signed [AMP_W-1:0] amplitude = 0;
    logic [WID_W-1:0] width = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [INDEX_W-1:0] index;
    logic in_air;
    logic [1:0] status;

    index_scoreboard board;
    bit quiet;
    int unsigned sink_gap;

    ice_refractive_index_profile_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .depth(depth), .amplitude(amplitude), .width(width),
        .out_valid(out_valid), .out_ready(out_ready),
        .index(index), .in_air(in_air), .status(status)
    );

    always #5 clk = ~clk;

    initial
    begin
        #80000000;
        $display("DONE: errors detected");
        $finish;
    end

    // check output beats and stall the result channel in bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(index, in_air, status);
            if (quiet)
                out_ready <= 1;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                out_ready <= 0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(1, 13);
                out_ready <= 0;
            end
            else
                out_ready <= 1;
        end
    end

    // hold valid across back-to-back beats; drop it only before idling
    task automatic send_command(act_t act, logic signed [23:0] z,
                                logic signed [16:0] a, logic [22:0] w);
        // idle the input side in bursts before some beats
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        depth <= z;
        amplitude <= a;
        width <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_command(act, z, a, w);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic write_model(logic [2:0] sel);
        drain();
        cfg_valid <= 1;
        cfg_data <= sel;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        board.model_sel = sel;
    endtask

    // random bump near the surface with a modest sigma
    task automatic add_random_bump();
        send_command(ACT_ADD, -$signed(24'($urandom_range(0, 200 * 256))),
                     17'($urandom), 23'($urandom_range(1, 20 * 256)));
    endtask

    task automatic eval_random();
        logic signed [23:0] z;
        case ($urandom_range(0, 3))
            0: z = 24'($urandom);
            1: z = -$signed(24'($urandom_range(0, 300 * 256)));
            2: z = -$signed(24'($urandom_range(0, 40 * 256)));
            default: z = 24'($urandom_range(0, 1024));
        endcase
        send_command(ACT_EVAL, z, 17'($urandom), 23'($urandom));
    endtask

    initial
    begin
        board = new();
        quiet = 0;
        sink_gap = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: surface, air, extremes, zero width, full table, clear, unused
        send_command(ACT_EVAL, 24'sd0, 17'sd0, 23'd0);
        send_command(ACT_EVAL, 24'sd1, 17'sd0, 23'd0);
        send_command(ACT_EVAL, 24'sh7FFFFF, 17'sd0, 23'd0);
        send_command(ACT_EVAL, 24'sh800000, 17'sh1FFFF, 23'h7FFFFF);
        send_command(ACT_ADD, -24'sd2560, 17'sd1000, 23'd0);
        send_command(ACT_ADD, 24'sh800000, 17'sh10000, 23'h7FFFFF);
        send_command(ACT_ADD, 24'sh7FFFFF, 17'sh0FFFF, 23'd1);
        send_command(ACT_ADD, -24'sd256, 17'sh0FFFF, 23'd2560);
        send_command(ACT_ADD, -24'sd512, 17'sh0FFFF, 23'd2560);
        send_command(ACT_ADD, -24'sd512, 17'sh0FFFF, 23'd5120);
        send_command(ACT_ADD, -24'sd768, 17'sh0FFFF, 23'd5120);
        send_command(ACT_ADD, -24'sd1024, 17'sh0FFFF, 23'd7680);
        send_command(ACT_ADD, -24'sd1280, 17'sh0FFFF, 23'd7680);
        send_command(ACT_ADD, -24'sd1, 17'sd5, 23'd0);
        send_command(ACT_ADD, -24'sd1, 17'sd5, 23'd9);
        send_command(ACT_EVAL, -24'sd512, 17'sd0, 23'd0);
        send_command(ACT_EVAL, 24'sh800000, 17'sd0, 23'd0);
        send_command(ACT_NONE, -24'sd512, 17'sd3, 23'd7);
        send_command(ACT_CLEAR, 24'sd0, 17'sd0, 23'd0);
        send_command(ACT_ADD, -24'sd256, 17'sh10000, 23'd256);
        send_command(ACT_ADD, -24'sd256, 17'sh10000, 23'd256);
        send_command(ACT_EVAL, -24'sd256, 17'sd0, 23'd0);
        send_command(ACT_CLEAR, 24'sd0, 17'sd0, 23'd0);

        // random: several model settings, each with fill, evaluate and clear
        for (int ph = 0; ph < 8; ph++)
        begin
            write_model((ph == 0) ? 3'd6 : (ph == 7) ? 3'd7 : 3'($urandom_range(0, 7)));
            if (ph == 3)
                drain();
            if (ph == 6)
                quiet = 1;
            for (int n = 0; n < 72; n++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: add_random_bump();
                    4: send_command(ACT_ADD, 24'($urandom), 17'($urandom), 23'($urandom));
                    5: send_command(ACT_CLEAR, 24'($urandom), 17'($urandom), 23'($urandom));
                    6: send_command(act_t'($urandom_range(0, 3)), 24'($urandom),
                                    17'($urandom), 23'($urandom_range(0, 1)));
                    default: eval_random();
                endcase
            end
            send_command(ACT_CLEAR, 24'sd0, 17'sd0, 23'd0);
        end
        write_model(3'd0);
        drain();

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire
